FILE: hw/rtl/rdd_pkg.sv
// Package for the rotation direction detector.
// Holds shared types, codes and register reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

  localparam int ANGLE_W  = 16;
  localparam int CENTRE_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST     = 16'd1000;
  localparam logic [LIMIT_W-1:0] CENTRE_LIMIT_RST    = 16'd640;
  localparam logic [LIMIT_W-1:0] DIR_THRESHOLD_RST   = 16'd100;

  localparam logic [REG_IDX_W-1:0] REG_ANGLE_LIMIT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTRE_LIMIT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIR_THRESHOLD = 2'd2;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ROT_STOP = 2'd0,
    ROT_CW   = 2'd1,
    ROT_ACW  = 2'd2
  } rot_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_EVAL,
    TOP_JUDGE,
    TOP_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    J_IDLE,
    J_RD_LO,
    J_RD_HI,
    J_ACC,
    J_FIN
  } judge_state_t;

  typedef struct packed {
    logic done;
    rot_t rotation;
  } judge_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rdd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 11
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire [WIDTH-1:0]          wr_data,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rdd_judge.sv
// Direction judgement sequencer: walks split-half history pairs through one
// subtract-accumulate unit. Depends on rdd_pkg; reads the history RAM.
`timescale 1ns / 1ps
`default_nettype none

module rdd_judge
  import rdd_pkg::*;
#(
  parameter int HISTORY_LEN = 11
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire [LIMIT_W-1:0]               threshold,
  output logic [$clog2(HISTORY_LEN)-1:0]  rd_addr,
  input  wire [ANGLE_W-1:0]               rd_data,
  output judge_status_t                   status
);

  localparam int HALF  = HISTORY_LEN / 2;
  localparam int AW    = $clog2(HISTORY_LEN);
  localparam int CW    = $clog2(HALF + 1);
  localparam int ACC_W = ANGLE_W + 2 + CW;
  localparam logic [AW-1:0] HALF_A = AW'(HALF);
  localparam logic [CW-1:0] LAST_IDX = CW'(HALF - 1);

  judge_state_t state, state_next;
  logic [CW-1:0]          idx;
  logic [ANGLE_W-1:0]     lo_val;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] bound;
  logic signed [ANGLE_W:0] diff;
  logic signed [ACC_W-1:0] neg_bound;

  assign diff = $signed({rd_data[ANGLE_W-1], rd_data}) - $signed({lo_val[ANGLE_W-1], lo_val});
  assign neg_bound = -bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= J_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      J_IDLE: begin
        if (start) begin
          idx   <= '0;
          sum   <= '0;
          bound <= '0;
        end
      end
      J_RD_HI: begin
        lo_val <= rd_data;
      end
      J_ACC: begin
        if (diff != '0) begin
          sum   <= sum + ACC_W'(diff);
          bound <= bound + $signed({{(ACC_W-LIMIT_W){1'b0}}, threshold});
        end
        idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    rd_addr         = AW'(idx);
    status.done     = 1'b0;
    status.rotation = ROT_STOP;
    case (state)
      J_IDLE: begin
        if (start) begin
          state_next = J_RD_LO;
        end
      end
      J_RD_LO: begin
        state_next = J_RD_HI;
      end
      J_RD_HI: begin
        rd_addr    = HALF_A + AW'(idx);
        state_next = J_ACC;
      end
      J_ACC: begin
        state_next = (idx == LAST_IDX) ? J_FIN : J_RD_LO;
      end
      J_FIN: begin
        status.done = 1'b1;
        if (sum < neg_bound) begin
          status.rotation = ROT_CW;
        end else if (sum > bound) begin
          status.rotation = ROT_ACW;
        end
        state_next = J_IDLE;
      end
      default: begin
        state_next = J_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rotation_direction_detector_top.sv
// Rotation direction detector: an accepted sample is evaluated in TOP_EVAL and the
// result register loads in TOP_DONE once the output is free; the deciding sample
// first walks its history pairs through the shared subtract-accumulate unit in
// rdd_judge. Input ready only while idle; one transaction in flight.
// Synchronous reset clears flags, previous sample, history count and registers
// to defaults; history RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rotation_direction_detector_top
  import rdd_pkg::*;
#(
  parameter int HISTORY_LEN = 11
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [47:0]           s_tdata,   // blade_angle, centre_x, centre_y
  input  wire                  s_tuser,   // mode
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [7:0]           m_tdata,   // rotation[1:0], same_blade, decided
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [REG_IDX_W-1:0]  cfg_index,
  input  wire [LIMIT_W-1:0]    cfg_data
);

  localparam int AW = $clog2(HISTORY_LEN);
  localparam int FW = $clog2(HISTORY_LEN + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_LEN);

  function automatic logic [ANGLE_W:0] abs17(input logic signed [ANGLE_W:0] v);
    abs17 = v[ANGLE_W] ? -v : v;
  endfunction

  top_state_t state, state_next;

  logic [LIMIT_W-1:0]  angle_limit;
  logic [LIMIT_W-1:0]  centre_limit;
  logic [LIMIT_W-1:0]  dir_threshold;

  logic                in_mode;
  logic [ANGLE_W-1:0]  in_angle;
  logic [CENTRE_W-1:0] in_cx;
  logic [CENTRE_W-1:0] in_cy;

  logic [ANGLE_W-1:0]  prev_angle;
  logic [CENTRE_W-1:0] prev_cx;
  logic [CENTRE_W-1:0] prev_cy;
  logic [FW-1:0]       fill;
  logic [FW-1:0]       fill_next;
  logic                same_blade_flag;
  logic                decided_flag;
  rot_t                rotation_reg;

  logic [ANGLE_W:0]    angle_abs;
  logic [CENTRE_W:0]   cx_abs;
  logic [CENTRE_W:0]   cy_abs;
  logic                same;
  logic                wr_en;
  logic                judge_start;
  logic [AW-1:0]       rd_addr;
  logic [ANGLE_W-1:0]  rd_data;
  judge_status_t       jstat;
  logic                out_load;

  assign s_tready  = (state == TOP_IDLE);
  assign cfg_ready = 1'b1;

  assign angle_abs = abs17($signed({in_angle[ANGLE_W-1], in_angle})
                         - $signed({prev_angle[ANGLE_W-1], prev_angle}));
  assign cx_abs = abs17($signed({1'b0, in_cx}) - $signed({1'b0, prev_cx}));
  assign cy_abs = abs17($signed({1'b0, in_cy}) - $signed({1'b0, prev_cy}));
  assign same = (angle_abs <= {1'b0, angle_limit}) && (cx_abs <= {1'b0, centre_limit})
             && (cy_abs <= {1'b0, centre_limit});

  always_comb begin
    if (!same) begin
      fill_next = '0;
    end else if (fill < FILL_MAX) begin
      fill_next = fill + 1'b1;
    end else begin
      fill_next = fill;
    end
  end

  assign wr_en = (state == TOP_EVAL) && (in_mode == MODE_SAMPLE) && !decided_flag
              && same && (fill < FILL_MAX);
  assign judge_start = (state == TOP_EVAL) && (in_mode == MODE_SAMPLE) && !decided_flag
                    && (fill_next >= FILL_MAX);
  assign out_load = (state == TOP_DONE) && (!m_tvalid || m_tready);

  rdd_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (HISTORY_LEN)
  ) u_history (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (in_angle),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rdd_judge #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_judge (
    .clk       (clk),
    .rst       (rst),
    .start     (judge_start),
    .threshold (dir_threshold),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .status    (jstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      TOP_IDLE: begin
        if (s_tvalid) begin
          state_next = TOP_EVAL;
        end
      end
      TOP_EVAL: begin
        state_next = judge_start ? TOP_JUDGE : TOP_DONE;
      end
      TOP_JUDGE: begin
        if (jstat.done) begin
          state_next = TOP_DONE;
        end
      end
      TOP_DONE: begin
        if (out_load) begin
          state_next = TOP_IDLE;
        end
      end
      default: begin
        state_next = TOP_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_limit   <= ANGLE_LIMIT_RST;
      centre_limit  <= CENTRE_LIMIT_RST;
      dir_threshold <= DIR_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_LIMIT:   angle_limit   <= cfg_data;
        REG_CENTRE_LIMIT:  centre_limit  <= cfg_data;
        REG_DIR_THRESHOLD: dir_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode  <= s_tuser;
      in_angle <= s_tdata[15:0];
      in_cx    <= s_tdata[31:16];
      in_cy    <= s_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle      <= '0;
      prev_cx         <= '0;
      prev_cy         <= '0;
      fill            <= '0;
      same_blade_flag <= 1'b0;
      decided_flag    <= 1'b0;
      rotation_reg    <= ROT_STOP;
    end else if (state == TOP_EVAL) begin
      if (in_mode == MODE_RESTART) begin
        decided_flag    <= 1'b0;
        same_blade_flag <= 1'b0;
        fill            <= '0;
      end else if (!decided_flag) begin
        same_blade_flag <= same;
        fill            <= fill_next;
        prev_angle      <= in_angle;
        prev_cx         <= in_cx;
        prev_cy         <= in_cy;
        if (judge_start) begin
          decided_flag <= 1'b1;
        end else begin
          rotation_reg <= ROT_STOP;
        end
      end
    end else if (state == TOP_JUDGE && jstat.done) begin
      rotation_reg <= jstat.rotation;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0000, decided_flag, same_blade_flag, rotation_reg};
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == TOP_DONE)
    else $error("result presented without finishing a transaction");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("history count beyond history length");

  a_decide_on_judge: assert property (@(posedge clk) disable iff (rst)
    $rose(decided_flag) |-> $past(judge_start))
    else $error("direction latched without a judgement");

  a_judge_only_when_idle_in: assert property (@(posedge clk) disable iff (rst)
    (state == TOP_JUDGE) |-> !s_tready)
    else $error("input ready during judgement");

endmodule

`default_nettype wire
